>>> rtl/scd_pkg.sv
// Shared types, constants and helpers of the 37-point corner detector.
// Used by every module under rtl; depends on nothing.
package scd_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MASK_RADIUS   = 3;
    localparam int WIN           = 2 * MASK_RADIUS + 1;
    localparam int MASK_POINTS   = 37;
    localparam int HEIGHT_CAP    = 2048;
    localparam int DIM_MIN       = 4;
    localparam int ROW_W         = 12;
    localparam int POS_W         = 14;

    localparam logic [7:0]  BT_RESET = 8'd101;
    localparam logic [5:0]  GT_RESET = 6'd9;
    localparam logic [11:0] IW_RESET = 12'd640;
    localparam logic [11:0] IH_RESET = 12'd480;

    typedef enum logic [1:0] {
        CFG_BT     = 2'd0,
        CFG_GT     = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic       mode;
        logic [7:0] gray_pixel;
    } t_in;

    typedef struct packed {
        logic        corner_flag;
        logic [5:0]  corner_response;
        logic [10:0] pixel_row;
        logic [10:0] pixel_column;
        logic        frame_last;
    } t_out;

    // per-word control tag carried down the pipe
    typedef struct packed {
        logic [7:0]  pix;
        logic [1:0]  vlo;
        logic [1:0]  vhi;
        logic [1:0]  clo;
        logic [1:0]  chi;
        logic        cin;
        logic        emit;
        logic        last;
        logic        ledge;
        logic        redge;
        logic [10:0] orow;
        logic [10:0] ocol;
    } t_tag;

    typedef logic [WIN-1:0][7:0] t_gvec;
    typedef logic [2:0][5:0]     t_rvec;

    // slot of a reflected tap, lo/hi = distance to first/last row or column, capped at 3
    function automatic logic [2:0] refl_slot(input int d, input logic [1:0] lo,
                                             input logic [1:0] hi);
        int s;
        if (d < -int'(lo)) begin
            s = 2 - 2 * int'(lo) - d;
        end else if (d > int'(hi)) begin
            s = 2 * int'(hi) + 4 - d;
        end else begin
            s = d + MASK_RADIUS;
        end
        return 3'(s);
    endfunction

    function automatic int mask_span(input int dy);
        int s;
        if (dy == 3 || dy == -3) begin
            s = 1;
        end else if (dy == 2 || dy == -2) begin
            s = 2;
        end else begin
            s = 3;
        end
        return s;
    endfunction

    function automatic logic [1:0] clip3(input logic signed [POS_W-1:0] v);
        return (v >= 14'sd3) ? 2'd3 : v[1:0];
    endfunction

endpackage

>>> rtl/scd_gray_store.sv
// Gray line memory: one entry per column holding the last six rows.
// Read-modify-write per word, row reflection of the column vector. Uses scd_pkg.
module scd_gray_store #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rd,
    input  logic [CW-1:0]     i_rd_col,
    input  logic              i_wr,
    input  logic [CW-1:0]     i_wr_col,
    input  logic [7:0]        i_pix,
    input  logic [1:0]        i_lo,
    input  logic [1:0]        i_hi,
    output scd_pkg::t_gvec    o_vec
);
    import scd_pkg::*;

    localparam int EW = (WIN - 1) * 8;

    logic [EW-1:0] r_mem [MAX_WIDTH];
    logic [EW-1:0] r_rdata;
    t_gvec         w_col;

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_rdata <= r_mem[i_rd_col];
        end
        if (i_wr) begin
            r_mem[i_wr_col] <= {i_pix, r_rdata[EW-1:8]};
        end
    end

    always_comb begin
        w_col = {i_pix, r_rdata};
        for (int i = 0; i < WIN; i++) begin
            o_vec[i] = w_col[refl_slot(i - MASK_RADIUS, i_lo, i_hi)];
        end
    end

endmodule

>>> rtl/scd_resp_unit.sv
// 7x7 window of column vectors, 37 parallel similarity tests and the response.
// Uses scd_pkg.
module scd_resp_unit (
    input  logic           i_clk,
    input  logic           i_load,
    input  scd_pkg::t_gvec i_vec,
    input  logic           i_mv,
    input  logic [1:0]     i_clo,
    input  logic [1:0]     i_chi,
    input  logic [7:0]     i_bt,
    input  logic [5:0]     i_gt,
    input  logic           i_cin,
    output logic [5:0]     o_resp
);
    import scd_pkg::*;

    t_gvec                  r_win [WIN];
    logic [MASK_POINTS-1:0] r_sim;
    logic [MASK_POINTS-1:0] w_sim;
    logic [5:0]             w_cnt;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int j = 0; j < WIN - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[WIN-1] <= i_vec;
        end
        if (i_mv) begin
            r_sim <= w_sim;
        end
    end

    always_comb begin
        int         k;
        logic [7:0] a;
        logic [7:0] c;
        logic [7:0] d;
        k = 0;
        a = '0;
        d = '0;
        c = r_win[MASK_RADIUS][MASK_RADIUS];
        w_sim = '0;
        for (int dy = -MASK_RADIUS; dy <= MASK_RADIUS; dy++) begin
            for (int dx = -3; dx <= 3; dx++) begin
                if (dx >= -mask_span(dy) && dx <= mask_span(dy)) begin
                    a = r_win[refl_slot(dx, i_clo, i_chi)][dy + MASK_RADIUS];
                    d = (a > c) ? a - c : c - a;
                    w_sim[k] = (d <= i_bt);
                    k = k + 1;
                end
            end
        end
    end

    assign w_cnt  = 6'($countones(r_sim));
    assign o_resp = (i_cin && w_cnt < i_gt) ? i_gt - w_cnt : 6'd0;

endmodule

>>> rtl/scd_nms.sv
// Response line memory (two rows per column entry) and 3x3 non-maximum test.
// Uses scd_pkg.
module scd_nms #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rd,
    input  logic [CW-1:0] i_rd_col,
    input  logic          i_wr,
    input  logic [CW-1:0] i_wr_col,
    input  logic [5:0]    i_resp,
    input  logic          i_ledge,
    input  logic          i_redge,
    output logic          o_flag,
    output logic [5:0]    o_resp
);
    import scd_pkg::*;

    logic [11:0] r_mem [MAX_WIDTH];
    logic [11:0] r_rdata;
    t_rvec       r_nw [3];

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_rdata <= r_mem[i_rd_col];
        end
        if (i_wr) begin
            r_mem[i_wr_col] <= {r_rdata[5:0], i_resp};
            r_nw[0]         <= r_nw[1];
            r_nw[1]         <= r_nw[2];
            r_nw[2]         <= {i_resp, r_rdata[5:0], r_rdata[11:6]};
        end
    end

    always_comb begin
        logic [5:0] nb;
        o_resp = r_nw[1][1];
        o_flag = 1'b1;
        for (int cl = 0; cl < 3; cl++) begin
            for (int rw = 0; rw < 3; rw++) begin
                // neighbours past the left or right image edge count as zero
                if ((cl == 0 && i_ledge) || (cl == 2 && i_redge)) begin
                    nb = 6'd0;
                end else begin
                    nb = r_nw[cl][rw];
                end
                if (!(cl == 1 && rw == 1) && nb >= r_nw[1][1]) begin
                    o_flag = 1'b0;
                end
            end
        end
    end

endmodule

>>> rtl/susan_corner_detector_top.sv
// SUSAN corner detector top: takes one pixel or flush word per clock while o_stall is
// low and, once the pipe is full, gives one result word per input word through the
// r_tag1 to r_tag4 registers and the output register. A W x H frame takes W*H + 4*W + 4
// input words (flush words close it); results start after 4*W + 4 words. Unstalled, the
// rate is one word per clock, set by the gray memory read-modify-write. Uses scd_pkg.
module susan_corner_detector_top #(
    parameter int MAX_WIDTH = scd_pkg::MAX_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  scd_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output scd_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [11:0]   i_cfg_data
);
    import scd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [7:0]       r_bt;
    logic [5:0]       r_gt;
    logic [11:0]      r_iw;
    logic [11:0]      r_ih;
    logic [WW-1:0]    w_w;
    logic [11:0]      w_h;

    logic [ROW_W-1:0] r_row, n_row;
    logic [CW-1:0]    r_col, n_col;

    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic w_ld1, w_ld2, w_ld3, w_ld4, w_ld5;
    logic w_acc, w_mv1, w_mv2, w_mv3, w_mv4;

    t_tag          w_tag0, r_tag1, r_tag2, r_tag3, r_tag4;
    logic [CW-1:0] w_xa0, r_col1, r_xa1, r_xa2, r_xa3;
    t_out          r_out;

    t_gvec      w_vec;
    logic [5:0] w_resp;
    logic       w_flag;
    logic [5:0] w_cresp;
    logic       w_dim_wr;

    always_comb begin
        if (r_iw < 12'(DIM_MIN)) begin
            w_w = WW'(DIM_MIN);
        end else if (int'(r_iw) > MAX_WIDTH) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_iw);
        end
        if (r_ih < 12'(DIM_MIN)) begin
            w_h = 12'(DIM_MIN);
        end else if (int'(r_ih) > HEIGHT_CAP) begin
            w_h = 12'(HEIGHT_CAP);
        end else begin
            w_h = r_ih;
        end
    end

    // handshake: each stage loads when empty or when its word moves on
    assign w_ld5  = !r_ov || !i_stall;
    assign w_ld4  = !r_v4 || w_ld5;
    assign w_ld3  = !r_v3 || w_ld4;
    assign w_ld2  = !r_v2 || w_ld3;
    assign w_ld1  = !r_v1 || w_ld2;
    assign w_acc  = i_valid && w_ld1;
    assign w_mv1  = r_v1 && w_ld2;
    assign w_mv2  = r_v2 && w_ld3;
    assign w_mv3  = r_v3 && w_ld4;
    assign w_mv4  = r_v4 && w_ld5;
    assign o_stall = !w_ld1;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // positions derived from the input step: vector, response centre, reported pixel
    always_comb begin
        logic signed [POS_W-1:0] rr, cc, ww, hh, ys, xa, ya, oc, orw;
        rr = $signed(POS_W'(r_row));
        cc = $signed(POS_W'(r_col));
        ww = $signed(POS_W'(w_w));
        hh = $signed(POS_W'(w_h));
        ys = rr - 14'sd3;
        if (cc >= 14'sd3) begin
            xa = cc - 14'sd3;
            ya = rr - 14'sd3;
        end else begin
            xa = cc + ww - 14'sd3;
            ya = rr - 14'sd4;
        end
        if (cc >= 14'sd4) begin
            oc  = cc - 14'sd4;
            orw = rr - 14'sd4;
        end else begin
            oc  = cc + ww - 14'sd4;
            orw = rr - 14'sd5;
        end
        w_tag0.pix   = (r_row < w_h && !i_data.mode) ? i_data.gray_pixel : 8'd0;
        w_tag0.vlo   = clip3(ys);
        w_tag0.vhi   = clip3(hh - 14'sd1 - ys);
        w_tag0.clo   = clip3(xa);
        w_tag0.chi   = clip3(ww - 14'sd1 - xa);
        w_tag0.cin   = (ya >= 14'sd0) && (ya < hh);
        w_tag0.emit  = (orw >= 14'sd0);
        w_tag0.last  = (orw == hh - 14'sd1) && (oc == ww - 14'sd1);
        w_tag0.ledge = (oc == 14'sd0);
        w_tag0.redge = (oc == ww - 14'sd1);
        w_tag0.orow  = orw[10:0];
        w_tag0.ocol  = oc[10:0];
        w_xa0        = xa[CW-1:0];
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (r_row == w_h + 12'd4 && r_col == CW'(3)) begin
            n_row = '0;
            n_col = '0;
        end else if (WW'(r_col) == w_w - WW'(1)) begin
            n_row = r_row + 1'b1;
            n_col = '0;
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    assign w_dim_wr = i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_WIDTH ||
                                   t_cfg_idx'(i_cfg_index) == CFG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bt  <= BT_RESET;
            r_gt  <= GT_RESET;
            r_iw  <= IW_RESET;
            r_ih  <= IH_RESET;
            r_row <= '0;
            r_col <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BT:     r_bt <= i_cfg_data[7:0];
                    CFG_GT:     r_gt <= i_cfg_data[5:0];
                    CFG_WIDTH:  r_iw <= i_cfg_data;
                    CFG_HEIGHT: r_ih <= i_cfg_data;
                    default:    r_bt <= r_bt;
                endcase
            end
            if (w_dim_wr) begin
                r_row <= '0;
                r_col <= '0;
            end else if (w_acc) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            r_v1 <= w_acc ? 1'b1 : (w_mv1 ? 1'b0 : r_v1);
            r_v2 <= w_mv1 ? 1'b1 : (w_mv2 ? 1'b0 : r_v2);
            r_v3 <= w_mv2 ? 1'b1 : (w_mv3 ? 1'b0 : r_v3);
            r_v4 <= w_mv3 ? 1'b1 : (w_mv4 ? 1'b0 : r_v4);
            if (w_mv4 && r_tag4.emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_tag1 <= w_tag0;
            r_col1 <= r_col;
            r_xa1  <= w_xa0;
        end
        if (w_mv1) begin
            r_tag2 <= r_tag1;
            r_xa2  <= r_xa1;
        end
        if (w_mv2) begin
            r_tag3 <= r_tag2;
            r_xa3  <= r_xa2;
        end
        if (w_mv3) begin
            r_tag4 <= r_tag3;
        end
        if (w_mv4 && r_tag4.emit) begin
            r_out.corner_flag     <= w_flag;
            r_out.corner_response <= w_cresp;
            r_out.pixel_row       <= r_tag4.orow;
            r_out.pixel_column    <= r_tag4.ocol;
            r_out.frame_last      <= r_tag4.last;
        end
    end

    scd_gray_store #(.MAX_WIDTH(MAX_WIDTH)) u_gray (
        .i_clk    (i_clk),
        .i_rd     (w_acc),
        .i_rd_col (r_col),
        .i_wr     (w_mv1),
        .i_wr_col (r_col1),
        .i_pix    (r_tag1.pix),
        .i_lo     (r_tag1.vlo),
        .i_hi     (r_tag1.vhi),
        .o_vec    (w_vec)
    );

    scd_resp_unit u_resp (
        .i_clk  (i_clk),
        .i_load (w_mv1),
        .i_vec  (w_vec),
        .i_mv   (w_mv2),
        .i_clo  (r_tag2.clo),
        .i_chi  (r_tag2.chi),
        .i_bt   (r_bt),
        .i_gt   (r_gt),
        .i_cin  (r_tag3.cin),
        .o_resp (w_resp)
    );

    scd_nms #(.MAX_WIDTH(MAX_WIDTH)) u_nms (
        .i_clk    (i_clk),
        .i_rd     (w_mv2),
        .i_rd_col (r_xa2),
        .i_wr     (w_mv3),
        .i_wr_col (r_xa3),
        .i_resp   (w_resp),
        .i_ledge  (r_tag4.ledge),
        .i_redge  (r_tag4.redge),
        .o_flag   (w_flag),
        .o_resp   (w_cresp)
    );

endmodule

>>> verif/testbench.sv
// Testbench of susan_corner_detector_top: a scoreboard that predicts the corner
// map per frame, plus tasks that drive pixels, flush words and register writes.
// Depends on rtl/scd_pkg.sv and rtl/susan_corner_detector_top.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import scd_pkg::*;

    localparam int GROWS = 16;
    localparam int GCOLS = 2048;
    localparam int WDOG_LIMIT = 4000;
    localparam int LONG_HOLD = 300;

    class corner_scoreboard;
        byte unsigned gray[GROWS * GCOLS];
        int bright_thr, geo_thr, img_w, img_h;
        int wr_row, wr_col, step_pos;
        t_out expected_q[$];
        int errors;

        function new();
            foreach (gray[k]) gray[k] = 0;
            bright_thr = BT_RESET;
            geo_thr = GT_RESET;
            img_w = IW_RESET;
            img_h = IH_RESET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            wr_row = 0;
            wr_col = 0;
            step_pos = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [11:0] v);
            case (idx)
                CFG_BT: bright_thr = v[7:0];
                CFG_GT: geo_thr = v[5:0];
                CFG_WIDTH: begin
                    img_w = v;
                    restart();
                end
                CFG_HEIGHT: begin
                    img_h = v;
                    restart();
                end
                default: ;
            endcase
        endfunction

        function int clamp(int v);
            return (v < DIM_MIN) ? DIM_MIN : ((v > GCOLS) ? GCOLS : v);
        endfunction

        function int mirror(int x, int n);
            if (x < 0) return -x - 1;
            if (x >= n) return 2 * n - x - 1;
            return x;
        endfunction

        function int pix(int r, int c);
            return gray[(r & (GROWS - 1)) * GCOLS + (c % GCOLS)];
        endfunction

        function int response(int r, int c, int w, int h);
            int centre, cnt, span, d;
            cnt = 0;
            if (r < 0 || r >= h || c < 0 || c >= w) return 0;
            centre = pix(r, c);
            for (int dy = -3; dy <= 3; dy++) begin
                span = (dy == 3 || dy == -3) ? 1 : ((dy == 2 || dy == -2) ? 2 : 3);
                for (int dx = -span; dx <= span; dx++) begin
                    d = pix(mirror(r + dy, h), mirror(c + dx, w)) - centre;
                    if (d < 0) d = -d;
                    if (d <= bright_thr) cnt++;
                end
            end
            return (cnt < geo_thr) ? geo_thr - cnt : 0;
        endfunction

        function void note_word(t_in w_in);
            int w, h, npix, lag, total, s, p, r, c, rc;
            t_out e;
            w = clamp(img_w);
            h = clamp(img_h);
            npix = w * h;
            lag = 4 * w + 4;
            total = npix + lag;
            s = step_pos;
            if (s >= total) begin
                restart();
                s = 0;
            end
            if (s < npix) begin
                gray[(wr_row & (GROWS - 1)) * GCOLS + (wr_col % GCOLS)] =
                    w_in.mode ? 8'd0 : w_in.gray_pixel;
                wr_col++;
                if (wr_col >= w) begin
                    wr_col = 0;
                    wr_row++;
                end
            end
            if (s >= lag) begin
                p = s - lag;
                r = p / w;
                c = p % w;
                rc = response(r, c, w, h);
                e.corner_flag = 1'b1;
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                        if ((dy != 0 || dx != 0) && response(r + dy, c + dx, w, h) >= rc)
                            e.corner_flag = 1'b0;
                e.corner_response = rc[5:0];
                e.pixel_row = r[10:0];
                e.pixel_column = c[10:0];
                e.frame_last = (p == npix - 1);
                expected_q.push_back(e);
            end
            s++;
            if (s >= total) restart();
            else step_pos = s;
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check(t_out got);
            t_out e;
            if (expected_q.size() == 0) begin
                report("unexpected word, row", got.pixel_row, -1);
                return;
            end
            e = expected_q.pop_front();
            if (got.corner_flag !== e.corner_flag)
                report("corner_flag", got.corner_flag, e.corner_flag);
            if (got.corner_response !== e.corner_response)
                report("corner_response", got.corner_response, e.corner_response);
            if (got.pixel_row !== e.pixel_row)
                report("pixel_row", got.pixel_row, e.pixel_row);
            if (got.pixel_column !== e.pixel_column)
                report("pixel_column", got.pixel_column, e.pixel_column);
            if (got.frame_last !== e.frame_last)
                report("frame_last", got.frame_last, e.frame_last);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [11:0] i_cfg_data = '0;

    corner_scoreboard sb = new();
    int send_pct = 0;
    int recv_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int sent = 0;

    susan_corner_detector_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left <= LONG_HOLD;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_word(i_data);
        if (i_rst_n && o_valid && !i_stall) sb.check(o_data);
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task send_word(logic mode, logic [7:0] g);
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{mode: mode, gray_pixel: g};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    task wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_idx idx, logic [11:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    // style: 0 random, 1 blocky 0/255 shapes, 2 low-contrast; cut < 0 sends the full frame
    task run_frame(int style, int cut);
        int w, h, npix, total, r, c, blk;
        logic [7:0] g;
        w = sb.clamp(sb.img_w);
        h = sb.clamp(sb.img_h);
        npix = w * h;
        total = npix + 4 * w + 4;
        if (cut >= 0 && cut < total) total = cut;
        blk = $urandom_range(1, 3);
        for (int k = 0; k < total; k++) begin
            r = k / w;
            c = k % w;
            case (style)
                0: g = 8'($urandom_range(0, 255));
                1: g = (((r / blk) + (c / (blk + 1))) % 3 == 0) ? 8'd255 : 8'd0;
                default: g = 8'(100 + $urandom_range(0, 40));
            endcase
            if (style == 1 && $urandom_range(0, 9) == 0) g = 8'($urandom_range(0, 255));
            if (k < npix)
                send_word(k == 1 || $urandom_range(0, 49) == 0, g);
            else
                send_word(!(k == npix || $urandom_range(0, 9) == 0), g);
        end
    endtask

    task random_frames(int quota);
        int stop_at;
        stop_at = sent + quota;
        while (sent < stop_at) begin
            wait_drained();
            write_reg(CFG_WIDTH, 12'($urandom_range(4, 10)));
            write_reg(CFG_HEIGHT, 12'($urandom_range(4, 8)));
            if ($urandom_range(0, 1)) write_reg(CFG_BT, 12'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) write_reg(CFG_GT, 12'($urandom_range(0, 63)));
            run_frame($urandom_range(0, 2), -1);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest frame, threshold extremes, clamped dimensions
        write_reg(CFG_BT, 12'd0);
        write_reg(CFG_GT, 12'd38);
        write_reg(CFG_WIDTH, 12'd0);
        write_reg(CFG_HEIGHT, 12'd4);
        run_frame(1, -1);
        wait_drained();
        write_reg(CFG_BT, 12'd255);
        write_reg(CFG_GT, 12'd63);
        write_reg(CFG_WIDTH, 12'd5);
        write_reg(CFG_HEIGHT, 12'd0);
        run_frame(0, -1);

        send_pct = 21;
        recv_pct = 80;
        random_frames(100);

        // long receiver hold with the sender still offering, then a mid-frame drain
        wait_drained();
        write_reg(CFG_BT, 12'd40);
        write_reg(CFG_GT, 12'd20);
        write_reg(CFG_WIDTH, 12'd8);
        write_reg(CFG_HEIGHT, 12'd6);
        send_pct = 0;
        recv_pct = 0;
        for (int k = 0; k < 60; k++) begin
            if (k == 45) hold_asked++;
            send_word(1'b0, 8'($urandom_range(0, 255)));
        end
        wait_drained();
        for (int k = 60; k < 8 * 6 + 36; k++) send_word(1'b1, 8'd0);

        // abandoned frame, then a dimension write restarts it
        wait_drained();
        run_frame(0, 50);
        wait_drained();
        write_reg(CFG_WIDTH, 12'd6);

        send_pct = 80;
        recv_pct = 21;
        random_frames(100);
        send_pct = 0;
        recv_pct = 0;
        random_frames(100);

        // largest sizes, reached through out-of-range values, frames cut short
        wait_drained();
        write_reg(CFG_GT, 12'd30);
        write_reg(CFG_WIDTH, 12'hFFF);
        write_reg(CFG_HEIGHT, 12'd4);
        run_frame(1, 40);
        wait_drained();
        write_reg(CFG_WIDTH, 12'd2048);
        write_reg(CFG_HEIGHT, 12'd2048);
        write_reg(CFG_WIDTH, 12'd4);
        write_reg(CFG_HEIGHT, 12'hFFF);
        run_frame(2, 100);

        wait_drained();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/scd_pkg.sv
rtl/scd_gray_store.sv
rtl/scd_resp_unit.sv
rtl/scd_nms.sv
rtl/susan_corner_detector_top.sv
verif/testbench.sv
